/* src/hysalm_pkg.sv */
// Shared types, constants and register indexes for the hysteresis alarm block.
package hysalm_pkg;

    localparam int PCT_W       = 7;
    localparam int TICKS_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 8;

    localparam logic [TICKS_W-1:0] OFFLINE_COUNT_MAX = TICKS_W'(60000);

    localparam logic [PCT_W-1:0]   SOIL_ON_RESET     = PCT_W'(30);
    localparam logic [PCT_W-1:0]   SOIL_OFF_RESET    = PCT_W'(40);
    localparam logic [PCT_W-1:0]   RAIN_ON_RESET     = PCT_W'(80);
    localparam logic [PCT_W-1:0]   RAIN_OFF_RESET    = PCT_W'(30);
    localparam logic [TICKS_W-1:0] LINK_DELAY_RESET  = TICKS_W'(50);

    localparam logic [CFG_IDX_W-1:0] REG_SOIL_ON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOIL_OFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAIN_ON    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAIN_OFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_DELAY = 3'd4;

    typedef enum logic [1:0] {
        CAUSE_NONE = 2'd0,
        CAUSE_DRY  = 2'd1,
        CAUSE_RAIN = 2'd2,
        CAUSE_LINK = 2'd3
    } cause_t;

    typedef struct packed {
        logic [PCT_W-1:0]   soil_on_pct;
        logic [PCT_W-1:0]   soil_off_pct;
        logic [PCT_W-1:0]   rain_set_pct;
        logic [PCT_W-1:0]   rain_clr_pct;
        logic [TICKS_W-1:0] link_lost_delay;
    } cfg_t;

    typedef struct packed {
        logic             ack;
        logic             link_up;
        logic [PCT_W-1:0] rain_percent;
        logic [PCT_W-1:0] soil_percent;
    } tick_t;

    typedef struct packed {
        logic   mute_state;
        cause_t buzzer_mode;
        cause_t alarm_cause;
        logic   alarm_active;
    } result_t;

endpackage

/* src/hysalm_cfg.sv */
// Configuration register file for the hysteresis alarm thresholds and link delay.
module hysalm_cfg
    import hysalm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_SOIL_ON:    cfg_next.soil_on_pct     = wr_data[PCT_W-1:0];
                REG_SOIL_OFF:   cfg_next.soil_off_pct    = wr_data[PCT_W-1:0];
                REG_RAIN_ON:    cfg_next.rain_set_pct    = wr_data[PCT_W-1:0];
                REG_RAIN_OFF:   cfg_next.rain_clr_pct    = wr_data[PCT_W-1:0];
                REG_LINK_DELAY: cfg_next.link_lost_delay = wr_data[TICKS_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.soil_on_pct     <= SOIL_ON_RESET;
            cfg_reg.soil_off_pct    <= SOIL_OFF_RESET;
            cfg_reg.rain_set_pct    <= RAIN_ON_RESET;
            cfg_reg.rain_clr_pct    <= RAIN_OFF_RESET;
            cfg_reg.link_lost_delay <= LINK_DELAY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/hysalm_core.sv */
// Alarm state, cause selection, mute latch and the result register.
module hysalm_core
    import hysalm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    step,
    input  tick_t   tick,
    output result_t result
);

    logic               dry_reg,     dry_next;
    logic               rain_reg,    rain_next;
    logic [TICKS_W-1:0] offline_reg, offline_next;
    logic               online_reg,  online_next;
    logic               mute_reg,    mute_next;
    cause_t             muted_reg,   muted_next;
    result_t            result_reg,  result_next;
    cause_t             cause;

    always_comb
    begin
        // Link bookkeeping first; the cause below sees the updated count.
        online_next  = online_reg | tick.link_up;
        offline_next = offline_reg;
        if (tick.link_up)
            offline_next = '0;
        else if (offline_reg < OFFLINE_COUNT_MAX)
            offline_next = offline_reg + TICKS_W'(1);

        // Each flag applies only the test for its present value.
        if (!dry_reg)
            dry_next = (tick.soil_percent <= cfg.soil_on_pct);
        else
            dry_next = !(tick.soil_percent >= cfg.soil_off_pct);

        if (!rain_reg)
            rain_next = (tick.rain_percent >= cfg.rain_set_pct);
        else
            rain_next = !(tick.rain_percent <= cfg.rain_clr_pct);

        if (dry_next)
            cause = CAUSE_DRY;
        else if (rain_next)
            cause = CAUSE_RAIN;
        else if (!tick.link_up && online_next && (offline_next >= cfg.link_lost_delay))
            cause = CAUSE_LINK;
        else
            cause = CAUSE_NONE;

        mute_next  = mute_reg;
        muted_next = muted_reg;
        if (tick.ack)
        begin
            if ((cause == CAUSE_NONE) || mute_reg)
            begin
                mute_next  = 1'b0;
                muted_next = CAUSE_NONE;
            end
            else
            begin
                mute_next  = 1'b1;
                muted_next = cause;
            end
        end
        if ((cause == CAUSE_NONE) || (mute_next && (cause != muted_next)))
        begin
            mute_next  = 1'b0;
            muted_next = CAUSE_NONE;
        end

        // After the clearing rules a set mute always matches the cause.
        result_next.alarm_active = dry_next | rain_next | !tick.link_up;
        result_next.alarm_cause  = cause;
        result_next.buzzer_mode  = mute_next ? CAUSE_NONE : cause;
        result_next.mute_state   = mute_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_reg     <= 1'b0;
            rain_reg    <= 1'b0;
            offline_reg <= '0;
            online_reg  <= 1'b0;
            mute_reg    <= 1'b0;
            muted_reg   <= CAUSE_NONE;
        end
        else if (step)
        begin
            dry_reg     <= dry_next;
            rain_reg    <= rain_next;
            offline_reg <= offline_next;
            online_reg  <= online_next;
            mute_reg    <= mute_next;
            muted_reg   <= muted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= result_next;
    end

    assign result = result_reg;

    a_offline_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        offline_reg <= OFFLINE_COUNT_MAX)
        else $error("offline tick count passed its limit");

    a_mute_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        mute_reg |-> (muted_reg != CAUSE_NONE))
        else $error("mute latch set without a muted cause");

    a_link_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (step && tick.link_up) |=> (offline_reg == '0) && online_reg)
        else $error("link up did not clear the offline count");

    a_muted_result_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (!result_reg.mute_state || (result_reg.buzzer_mode == CAUSE_NONE
                  && result_reg.alarm_cause == muted_reg)))
        else $error("muted result still drives the buzzer");

endmodule

/* src/hysteresis_alarm_with_mute.sv */
// Top level: stream ports, input register and result handshake around the alarm core.
//
//  channel  | direction | beat fields (lowest bit first)
//  s_axis   | in        | soil_percent[6:0], rain_percent[13:7], link_up[14], ack[15]
//  m_axis   | out       | alarm_active[0], alarm_cause[2:1], buzzer_mode[4:3], mute_state[5]
//  cfg      | in        | cfg_index selects register, cfg_data carries the value
//
// One tick beat is taken every cycle while the result register can advance; each beat
// passes through the input register, then the result register.
// The state update happens as a beat moves from the input register to the result
// register, so throughput is set by that single step.
// A stalled m_axis holds the result; s_axis keeps taking beats until the input
// register is also full. Reset clears all alarm state and loads the default thresholds.
module hysteresis_alarm_with_mute
    import hysalm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // soil_percent[6:0], rain_percent[13:7], link_up[14], ack[15]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // alarm_active[0], alarm_cause[2:1], buzzer_mode[4:3], mute_state[5], zeros above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    step;
    result_t result;

    assign cfg_ready = 1'b1;

    // The result register can take a new value when it is empty or being drained.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            tick_reg <= tick_t'(s_axis_tdata);
    end

    hysalm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    hysalm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .tick   (tick_reg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, result};

endmodule
